// ===== sv/lfu_cache_lookup_and_replace_unit_defines.svh =====
// Assertion macros used by the RTL controller (lfu_ctrl).
`ifndef LFU_CACHE_LOOKUP_AND_REPLACE_UNIT_DEFINES_SVH
`define LFU_CACHE_LOOKUP_AND_REPLACE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define LFU_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define LFU_ASSERT(lbl, clk, rstn, prop)
`define LFU_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

    localparam int LFU_ENTRIES = 16;
    localparam int KEY_W       = 31;
    localparam int VAL_W       = 31;
    localparam int CNT_W       = 32;
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic load;    // latch request, clear scan accumulators
        logic rd;      // read entry at address
        logic upd;     // read is part of the rank/valid update pass
        logic decide;  // pick slot, write key/value/count record
        logic resp;    // load output register
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic hit;
        logic cap_zero;
    } t_status;

endpackage

// ===== sv/lfu_cache_lookup_and_replace_unit.sv =====
// LFU key/value cache, one transaction at a time.
// A get on a miss returns its result after the tag/count scan; a get on a hit
// returns it after the scan and then a rank update pass (one memory read port).
// A put runs the scan and the update pass (only the scan at capacity 0) before the
// next input is accepted; after a get, once its result is taken. Input stalls meanwhile.
// Synchronous active-low reset empties the cache and sets capacity to 16.
module lfu_cache_lookup_and_replace_unit import lfu_pkg::*; #(
    parameter int ENTRIES = LFU_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_kind,
    input  logic [KEY_W-1:0] i_lookup_key,
    input  logic [VAL_W-1:0] i_store_value,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_hit,
    output logic [VAL_W-1:0] o_read_value,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_cmd          cmd;
    t_status       status;
    logic [IW-1:0] addr;

    lfu_ctrl #(.ENTRIES(ENTRIES), .IW(IW)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .o_addr   (addr),
        .i_status (status)
    );

    lfu_datapath #(.ENTRIES(ENTRIES), .IW(IW)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .o_status      (status),
        .i_kind        (i_kind),
        .i_lookup_key  (i_lookup_key),
        .i_store_value (i_store_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

endmodule

// ===== sv/lfu_datapath.sv =====
module lfu_datapath import lfu_pkg::*; #(
    parameter int ENTRIES = LFU_ENTRIES,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [IW-1:0]    i_addr,
    output t_status          o_status,
    input  logic             i_kind,
    input  logic [KEY_W-1:0] i_lookup_key,
    input  logic [VAL_W-1:0] i_store_value,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_hit,
    output logic [VAL_W-1:0] o_read_value
);

    localparam int UW = $clog2(ENTRIES + 1);
    localparam int RW = IW;
    localparam int RECW = KEY_W + VAL_W + CNT_W;

    logic [CAP_W-1:0]   r_cap;
    logic [ENTRIES-1:0] r_valid;
    logic [RECW-1:0]    r_kv_mem [ENTRIES];
    logic [RW-1:0]      r_rank_mem [ENTRIES];

    logic [RECW-1:0]    r_rd_rec;
    logic [RW-1:0]      r_rd_rank;
    logic               r_p_vld;
    logic               r_p_upd;
    logic [IW-1:0]      r_p_idx;

    logic               r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;

    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [VAL_W-1:0]   r_hit_val;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic [RW-1:0]      r_hit_rank;
    logic [UW-1:0]      r_used;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic               r_vic_found;
    logic [IW-1:0]      r_vic_idx;
    logic [CNT_W-1:0]   r_vic_cnt;
    logic [RW-1:0]      r_vic_rank;

    logic               r_ins;
    logic               r_evict;
    logic [IW-1:0]      r_slot;
    logic [RW-1:0]      r_ref_rank;

    logic               r_out_hit;
    logic [VAL_W-1:0]   r_out_val;

    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic [CNT_W-1:0]   rd_cnt;
    logic               p_v;
    logic               vic_better;
    logic               full;
    logic [CAP_W-1:0]   eff_cap;
    logic               n_ins;
    logic               n_evict;
    logic [IW-1:0]      n_slot;
    logic [RECW-1:0]    n_rec;
    logic [RW-1:0]      rank_w;

    assign rd_key = r_rd_rec[RECW-1 -: KEY_W];
    assign rd_val = r_rd_rec[CNT_W +: VAL_W];
    assign rd_cnt = r_rd_rec[CNT_W-1:0];
    assign p_v    = r_valid[r_p_idx];

    assign vic_better = !r_vic_found || (rd_cnt < r_vic_cnt) ||
                        ((rd_cnt == r_vic_cnt) && (r_rd_rank > r_vic_rank));

    always_comb begin
        if (32'(r_cap) > 32'(ENTRIES)) begin
            eff_cap = CAP_W'(ENTRIES);
        end else begin
            eff_cap = r_cap;
        end
        full    = 32'(r_used) >= 32'(eff_cap);
        n_ins   = (r_kind == KIND_PUT) && !r_hit;
        n_evict = n_ins && full;
        if (!n_ins) begin
            n_slot = r_hit_idx;
        end else if (n_evict) begin
            n_slot = (r_free_found && (r_free_idx < r_vic_idx)) ? r_free_idx : r_vic_idx;
        end else begin
            n_slot = r_free_idx;
        end
        if (n_ins) begin
            n_rec = {r_key, r_val, CNT_W'(1)};
        end else begin
            n_rec = {r_key, (r_kind == KIND_PUT) ? r_val : r_hit_val,
                     (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + CNT_W'(1)};
        end
    end

    // new rank of the entry under the update pass
    always_comb begin
        rank_w = r_rd_rank;
        if (r_p_idx == r_slot) begin
            rank_w = '0;
        end else if (r_ins) begin
            if (r_evict && (r_rd_rank > r_ref_rank)) begin
                rank_w = r_rd_rank;
            end else begin
                rank_w = r_rd_rank + RW'(1);
            end
        end else if (r_rd_rank < r_ref_rank) begin
            rank_w = r_rd_rank + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_rec  <= r_kv_mem[i_addr];
            r_rd_rank <= r_rank_mem[i_addr];
        end
        if (i_cmd.decide) begin
            r_kv_mem[n_slot] <= n_rec;
        end
        if (r_p_vld && r_p_upd) begin
            r_rank_mem[r_p_idx] <= rank_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= CAP_RESET;
            r_valid      <= '0;
            r_p_vld      <= 1'b0;
            r_p_upd      <= 1'b0;
            r_p_idx      <= '0;
            r_hit        <= 1'b0;
            r_used       <= '0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
            r_ins        <= 1'b0;
            r_evict      <= 1'b0;
            r_out_hit    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_p_vld <= i_cmd.rd;
            r_p_upd <= i_cmd.upd;
            r_p_idx <= i_addr;
            if (i_cmd.load) begin
                r_kind       <= i_kind;
                r_key        <= i_lookup_key;
                r_val        <= i_store_value;
                r_hit        <= 1'b0;
                r_used       <= '0;
                r_free_found <= 1'b0;
                r_vic_found  <= 1'b0;
            end
            if (r_p_vld && !r_p_upd) begin
                if (p_v) begin
                    r_used <= r_used + UW'(1);
                    if (!r_hit && (rd_key == r_key)) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_p_idx;
                        r_hit_val  <= rd_val;
                        r_hit_cnt  <= rd_cnt;
                        r_hit_rank <= r_rd_rank;
                    end
                    if (vic_better) begin
                        r_vic_found <= 1'b1;
                        r_vic_idx   <= r_p_idx;
                        r_vic_cnt   <= rd_cnt;
                        r_vic_rank  <= r_rd_rank;
                    end
                end else if (!r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_p_idx;
                end
            end
            if (i_cmd.decide) begin
                r_ins      <= n_ins;
                r_evict    <= n_evict;
                r_slot     <= n_slot;
                r_ref_rank <= n_ins ? r_vic_rank : r_hit_rank;
            end
            if (r_p_vld && r_p_upd && r_ins) begin
                if (r_p_idx == r_slot) begin
                    r_valid[r_p_idx] <= 1'b1;
                end else if (r_evict && (r_p_idx == r_vic_idx)) begin
                    r_valid[r_p_idx] <= 1'b0;
                end
            end
            if (i_cmd.resp) begin
                r_out_hit <= r_hit;
                r_out_val <= r_hit ? r_hit_val : '0;
            end
        end
    end

    assign o_status.kind     = r_kind;
    assign o_status.hit      = r_hit;
    assign o_status.cap_zero = (r_cap == '0);
    assign o_hit             = r_out_hit;
    assign o_read_value      = r_out_val;

endmodule

// ===== sv/lfu_ctrl.sv =====
`include "lfu_cache_lookup_and_replace_unit_defines.svh"

module lfu_ctrl import lfu_pkg::*; #(
    parameter int ENTRIES = LFU_ENTRIES,
    parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_addr,
    input  t_status       i_status
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_UPD, S_UDRAIN, S_RESP
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_idx;
    logic          r_busy;
    logic          r_out_valid;
    logic          accept;
    logic          last;

    assign accept = i_valid && !r_busy;
    assign last   = (r_idx == IW'(ENTRIES - 1));

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = accept;
        o_cmd.rd     = (r_state == S_SCAN) || (r_state == S_UPD);
        o_cmd.upd    = (r_state == S_UPD);
        o_cmd.decide = (r_state == S_DECIDE) &&
                       !((i_status.kind == KIND_GET) && !i_status.hit) &&
                       !((i_status.kind == KIND_PUT) && i_status.cap_zero);
        o_cmd.resp   = ((r_state == S_DECIDE) && (i_status.kind == KIND_GET) &&
                        !i_status.hit) ||
                       ((r_state == S_UDRAIN) && (i_status.kind == KIND_GET));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_busy  <= 1'b1;
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + IW'(1);
                    if (last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    if (o_cmd.resp) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_RESP;
                    end else if (o_cmd.decide) begin
                        r_state <= S_UPD;
                    end else begin
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_UPD: begin
                    r_idx <= r_idx + IW'(1);
                    if (last) begin
                        r_state <= S_UDRAIN;
                    end
                end
                S_UDRAIN: begin
                    if (o_cmd.resp) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_RESP;
                    end else begin
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                        r_busy      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_out_valid;
    assign o_addr  = r_idx;

    `LFU_ASSERT(a_valid_busy, i_clk, i_rst_n, r_out_valid |-> r_busy)
    `LFU_ASSERT(a_accept_scan, i_clk, i_rst_n, accept |=> (r_busy && r_state == S_SCAN))
    `LFU_ASSERT(a_drain_decide, i_clk, i_rst_n, (r_state == S_DRAIN) |=> (r_state == S_DECIDE))
    `LFU_ASSERT_NEVER(a_idle_busy, i_clk, i_rst_n, (r_state == S_IDLE) && r_out_valid)

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import lfu_pkg::*;

    localparam int N_ENT = LFU_ENTRIES;
    localparam int CYCLE_LIMIT = 900000;
    localparam int DUE_DEPTH = 1024;
    localparam int POOL_DEPTH = 64;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    logic             i_kind = KIND_GET;
    logic [KEY_W-1:0] i_lookup_key = '0;
    logic [VAL_W-1:0] i_store_value = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic             o_hit;
    logic [VAL_W-1:0] o_read_value;
    logic             i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata = '0;

    lfu_cache_lookup_and_replace_unit dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_lookup;

    // shadow cache
    logic             sh_valid [N_ENT];
    logic [KEY_W-1:0] sh_key [N_ENT];
    logic [VAL_W-1:0] sh_val [N_ENT];
    logic [CNT_W-1:0] sh_cnt [N_ENT];
    int unsigned      sh_rank [N_ENT];
    logic [CAP_W-1:0] sh_cap = CAP_RESET;

    t_lookup lookups_due [DUE_DEPTH];
    int n_due_wr = 0;
    int n_due_rd = 0;
    int n_fail = 0;
    int n_checked = 0;
    int n_hits = 0;
    int n_sent = 0;
    int cycles = 0;
    int burst_left = 0;
    logic [KEY_W-1:0] key_pool [POOL_DEPTH];
    int n_pool = 0;

    function automatic void promote(int s);
        for (int i = 0; i < N_ENT; i++)
            if (sh_valid[i] && i != s && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
        sh_rank[s] = 0;
        if (sh_cnt[s] != '1) sh_cnt[s]++;
    endfunction

    function automatic void predict_request(logic kind, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
        int slot;
        int used;
        int cap;
        int victim;
        int free_s;
        t_lookup r;
        slot = -1;
        used = 0;
        victim = -1;
        free_s = -1;
        for (int i = 0; i < N_ENT; i++)
            if (sh_valid[i] && sh_key[i] == key && slot < 0) slot = i;
        if (kind == KIND_GET) begin
            r.hit = (slot >= 0);
            r.value = '0;
            if (slot >= 0) begin
                promote(slot);
                r.value = sh_val[slot];
            end
            lookups_due[n_due_wr % DUE_DEPTH] = r;
            n_due_wr++;
            return;
        end
        cap = (sh_cap > N_ENT) ? N_ENT : int'(sh_cap);
        if (cap == 0) return;
        if (slot >= 0) begin
            sh_val[slot] = val;
            promote(slot);
            return;
        end
        for (int i = 0; i < N_ENT; i++) if (sh_valid[i]) used++;
        if (used >= cap) begin
            for (int i = 0; i < N_ENT; i++) begin
                if (!sh_valid[i]) continue;
                if (victim < 0 || sh_cnt[i] < sh_cnt[victim] ||
                    (sh_cnt[i] == sh_cnt[victim] && sh_rank[i] > sh_rank[victim]))
                    victim = i;
            end
            if (victim >= 0) begin
                sh_valid[victim] = 1'b0;
                for (int i = 0; i < N_ENT; i++)
                    if (sh_valid[i] && sh_rank[i] > sh_rank[victim]) sh_rank[i]--;
            end
        end
        for (int i = N_ENT - 1; i >= 0; i--) if (!sh_valid[i]) free_s = i;
        if (free_s < 0) return;
        for (int i = 0; i < N_ENT; i++) if (sh_valid[i]) sh_rank[i]++;
        sh_valid[free_s] = 1'b1;
        sh_key[free_s] = key;
        sh_val[free_s] = val;
        sh_cnt[free_s] = 1;
        sh_rank[free_s] = 0;
    endfunction

    // one transaction; bursts with random gaps
    task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_lookup_key <= key;
        i_store_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(kind, key, val);
        n_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (n_due_wr != n_due_rd) @(negedge i_clk);
        // a put has no result; let the last one finish
        repeat (2 * N_ENT + 10) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sh_cap = cap;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (n_pool == 0 || $urandom_range(0, 9) == 0)
            return KEY_W'($urandom());
        return key_pool[$urandom_range(0, n_pool - 1)];
    endfunction

    // receiver stall pattern and result checking
    always @(negedge i_clk) begin
        case (cycles / 700 % 3)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 2) == 0);
            default: i_stall <= ((cycles % 37) < 20);
        endcase
    end

    always @(posedge i_clk) begin
        t_lookup want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (n_due_wr == n_due_rd) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected lookup result hit=%0b", o_hit);
            end else begin
                want = lookups_due[n_due_rd % DUE_DEPTH];
                n_due_rd++;
                n_checked++;
                if (want.hit) n_hits++;
                if (o_hit !== want.hit || o_read_value !== want.value) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("lookup mismatch: exp hit=%0b val=%0h, got hit=%0b val=%0h",
                                 want.hit, want.value, o_hit, o_read_value);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(KIND_GET, '0, '1);
        send_request(KIND_PUT, '0, '1);
        send_request(KIND_PUT, '1, '0);
        send_request(KIND_GET, '0, '0);
        send_request(KIND_GET, '1, '1);
        send_request(KIND_PUT, '1, 31'h2AAA_AAAA);
        send_request(KIND_GET, '1, '0);
        for (int i = 0; i < 18; i++) send_request(KIND_PUT, KEY_W'(100 + i), VAL_W'(i));
        send_request(KIND_GET, '1, '0);
        send_request(KIND_GET, KEY_W'(100), '0);
        send_request(KIND_GET, KEY_W'(117), '0);
    endtask

    task automatic test_capacity_zero();
        write_capacity('0);
        send_request(KIND_PUT, KEY_W'(7), VAL_W'(7));
        send_request(KIND_GET, KEY_W'(7), '0);
        send_request(KIND_GET, KEY_W'(117), '0);
    endtask

    task automatic test_capacity_high();
        write_capacity('1);
        for (int i = 0; i < 4; i++) send_request(KIND_PUT, KEY_W'(200 + i), VAL_W'(i));
        send_request(KIND_GET, KEY_W'(200), '0);
    endtask

    task automatic test_random_phase(logic [CAP_W-1:0] cap, int n_items);
        logic kind;
        logic [KEY_W-1:0] key;
        write_capacity(cap);
        n_pool = 0;
        for (int i = 0; i < int'(cap) + 6; i++) begin
            key_pool[n_pool] = KEY_W'($urandom());
            n_pool++;
        end
        for (int i = 0; i < n_items; i++) begin
            kind = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
            key = pick_key();
            send_request(kind, key, VAL_W'($urandom()));
            if (i == n_items / 2) drain();
        end
    endtask

    initial begin
        for (int i = 0; i < N_ENT; i++) begin
            sh_valid[i] = 1'b0;
            sh_key[i] = '0;
            sh_val[i] = '0;
            sh_cnt[i] = '0;
            sh_rank[i] = 0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_capacity_zero();
        test_capacity_high();
        test_random_phase(5'd1, 80);
        test_random_phase(5'd4, 140);
        test_random_phase(5'd16, 120);
        test_random_phase(5'd9, 120);
        // lowered below occupancy: occupancy stays put
        test_random_phase(5'd3, 100);
        test_random_phase(5'd0, 20);
        test_random_phase(5'd16, 40);
        drain();
        $display("sent %0d requests, checked %0d lookups (%0d hits)",
                 n_sent, n_checked, n_hits);
        $display("capacities 0, 1, 3, 4, 9, 16 and 31 exercised, %0d mismatches", n_fail);
        if (n_fail == 0 && n_due_wr == n_due_rd)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_datapath.sv
sv/lfu_ctrl.sv
sv/lfu_cache_lookup_and_replace_unit.sv
bench/tb_top.sv
